// ===== hdl/asavg_pkg.sv =====
// Package for the converter scan averager: widths, register indexes,
// beat types and the configuration bundle.
// Depends on nothing; every other file in hdl uses it.
`timescale 1ns / 1ps

package asavg_pkg;

  // Defaults for the top-level parameters.
  localparam int CHANNELS_DEF     = 8;
  localparam int SAMPLE_SHIFT_DEF = 4;

  // Fixed field widths.
  localparam int SAMPLE_W    = 10;
  localparam int SLOT_W      = 3;
  localparam int MUX_W       = 4;
  localparam int ACC_W       = 16;
  localparam int COUNT_W     = 4;
  localparam int MUX_TABLE_W = 32;

  // Configuration port.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MUX_TABLE     = CFG_INDEX_W'(1);

  // Stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Item kinds carried in the input tuser.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0]     channel_count;
    logic [MUX_TABLE_W-1:0] mux_table;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
    logic [SLOT_W-1:0]   read_channel;
    logic                conv_busy;
  } item_t;

  typedef struct packed {
    logic [MUX_W-1:0]    mux_code;
    logic [SAMPLE_W-1:0] read_value;
    logic                window_done;
    logic [SLOT_W-1:0]   finished_slot;
    logic                start_conversion;
  } result_t;

endpackage

// ===== hdl/asavg_cfg_regs.sv =====
// Configuration register file of the scan averager: slot count and mux table.
// Depends on asavg_pkg.
`timescale 1ns / 1ps

module asavg_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [asavg_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [asavg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output asavg_pkg::cfg_t                     cfg_o
);

  asavg_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // Writes to indexes past the mux table are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        asavg_pkg::REG_CHANNEL_COUNT: begin
          cfg_d.channel_count = cfg_data_i[asavg_pkg::COUNT_W-1:0];
        end
        asavg_pkg::REG_MUX_TABLE: begin
          cfg_d.mux_table = cfg_data_i[asavg_pkg::MUX_TABLE_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= asavg_pkg::COUNT_W'(1);
      cfg_q.mux_table     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/asavg_scan_core.sv =====
// Scan state of the averager (window accumulator, slot pointer, stored
// averages) and the single-pass logic that turns one item into its result.
// Depends on asavg_pkg.
`timescale 1ns / 1ps

module asavg_scan_core #(
  parameter int CHANNELS     = asavg_pkg::CHANNELS_DEF,
  parameter int SAMPLE_SHIFT = asavg_pkg::SAMPLE_SHIFT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  asavg_pkg::item_t   item_i,
  input  asavg_pkg::cfg_t    cfg_i,
  output asavg_pkg::result_t result_o
);

  localparam int CNT_W = SAMPLE_SHIFT + 1;
  localparam logic [CNT_W-1:0] WINDOW = CNT_W'(1 << SAMPLE_SHIFT);
  localparam logic [asavg_pkg::COUNT_W-1:0] CH_COUNT = asavg_pkg::COUNT_W'(CHANNELS);

  logic [asavg_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [asavg_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [asavg_pkg::SAMPLE_W-1:0] avg_q [CHANNELS];

  logic [asavg_pkg::COUNT_W-1:0]  eff_count;
  logic [asavg_pkg::COUNT_W-1:0]  next_slot;
  logic                           closing;
  logic [asavg_pkg::SAMPLE_W-1:0] new_avg;
  logic [asavg_pkg::SAMPLE_W-1:0] rd_value;
  logic [asavg_pkg::SLOT_W+1:0]   mux_lsb;

  // A slot count of zero acts as one; one above the store depth is clamped.
  always_comb begin
    if (cfg_i.channel_count == '0) begin
      eff_count = asavg_pkg::COUNT_W'(1);
    end else if (cfg_i.channel_count > CH_COUNT) begin
      eff_count = CH_COUNT;
    end else begin
      eff_count = cfg_i.channel_count;
    end
  end

  assign closing   = (item_i.kind == asavg_pkg::KIND_SAMPLE) && (cnt_q >= WINDOW);
  assign next_slot = {1'b0, slot_q} + asavg_pkg::COUNT_W'(1);
  assign new_avg   = acc_q[SAMPLE_SHIFT +: asavg_pkg::SAMPLE_W];

  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    slot_d = slot_q;
    if (item_i.kind == asavg_pkg::KIND_SAMPLE) begin
      if (closing) begin
        // The closing sample itself is not added to anything.
        acc_d  = '0;
        cnt_d  = '0;
        slot_d = (next_slot >= eff_count) ? '0 : next_slot[asavg_pkg::SLOT_W-1:0];
      end else begin
        acc_d = acc_q + asavg_pkg::ACC_W'(item_i.sample);
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  // Readback mux over the stored averages; slots past the store read zero.
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (item_i.read_channel == asavg_pkg::SLOT_W'(i)) begin
        rd_value = avg_q[i];
      end
    end
  end

  assign mux_lsb = {slot_d, 2'b00};

  always_comb begin
    result_o.mux_code         = cfg_i.mux_table[mux_lsb +: asavg_pkg::MUX_W];
    result_o.read_value       = (item_i.kind == asavg_pkg::KIND_READ) ? rd_value : '0;
    result_o.window_done      = closing;
    result_o.finished_slot    = closing ? slot_q : '0;
    result_o.start_conversion = (item_i.kind == asavg_pkg::KIND_READ) && !item_i.conv_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      slot_q <= '0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      slot_q <= slot_d;
    end
  end

  // A slot pointer left past the store depth stores nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        avg_q[i] <= '0;
      end
    end else if (step_i && closing) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (slot_q == asavg_pkg::SLOT_W'(i)) begin
          avg_q[i] <= new_avg;
        end
      end
    end
  end

endmodule

// ===== hdl/adc_scan_averager.sv =====
// Top level of the round-robin converter scan averager.
// Depends on asavg_pkg, asavg_cfg_regs and asavg_scan_core.
`timescale 1ns / 1ps

// The block walks a list of converter slots round robin. Each sample beat
// (tuser kind = 0) is added to a window of 2^SAMPLE_SHIFT samples; the beat
// after a full window closes it, is itself dropped, stores the window sum
// shifted right by SAMPLE_SHIFT as the slot's average, and moves on to the
// next slot, reported by its mux code. A read beat (kind = 1) returns the
// stored average of the slot it names and asks for a conversion when the
// converter is idle. Every input beat gives exactly one result beat. The
// block takes one beat per clock cycle unless the result side stalls;
// a beat passes the input register and then the result register, and the
// whole update of the scan state happens in the single logic pass between
// them. Backpressure on the result side stalls both registers together,
// so a result waiting to be taken blocks the next input beat once the
// input register is full. Configuration writes are always taken and
// should only be issued while no beat is in flight. There is no clearing
// pass after reset: the averages store comes out of reset at zero.

module adc_scan_averager #(
  parameter int CHANNELS     = asavg_pkg::CHANNELS_DEF,     // 1 to 8
  parameter int SAMPLE_SHIFT = asavg_pkg::SAMPLE_SHIFT_DEF  // 0 to 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [asavg_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [asavg_pkg::CFG_DATA_W-1:0]   cfg_data_i,

  // Item stream in.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample [9:0], read_channel [12:10], conv_busy [13], zero [15:14]
  input  logic [asavg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // kind [0]
  input  logic                               s_axis_tuser,

  // Result stream out.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // mux_code [3:0], read_value [13:4], window_done [14], finished_slot [17:15],
  // start_conversion [18], zero [23:19]
  output logic [asavg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  asavg_pkg::cfg_t    cfg;
  asavg_pkg::item_t   item_q, item_d;
  asavg_pkg::result_t res_comb, res_q;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               advance;

  asavg_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The registered item moves on whenever the result register is free or
  // is being emptied in this same cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    item_d.kind         = s_axis_tuser;
    item_d.sample       = s_axis_tdata[9:0];
    item_d.read_channel = s_axis_tdata[12:10];
    item_d.conv_busy    = s_axis_tdata[13];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_d;
    end
  end

  // The scan state commits exactly when the item's result is registered.
  asavg_scan_core #(
    .CHANNELS     (CHANNELS),
    .SAMPLE_SHIFT (SAMPLE_SHIFT)
  ) u_scan_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_comb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000,
                          res_q.start_conversion,
                          res_q.finished_slot,
                          res_q.window_done,
                          res_q.read_value,
                          res_q.mux_code};

endmodule

// ===== dv/adc_scan_averager_tb.sv =====
// Self-checking testbench for the round-robin converter scan averager.
// Predicts every result beat from its own scan and average model.
// Depends on asavg_pkg and the adc_scan_averager RTL.
`timescale 1ns / 1ps

module adc_scan_averager_tb;
  import asavg_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SCAN_ITEMS   = 1400;
  localparam int SHOW_LIMIT   = 10;
  localparam int NCH          = CHANNELS_DEF;
  localparam int SHIFT        = SAMPLE_SHIFT_DEF;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data  = '0;
  logic                   s_user  = KIND_SAMPLE;

  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;

  // Shadow of the block's registers and scan state.
  logic [COUNT_W-1:0]     chan_count_q = COUNT_W'(1);
  logic [MUX_TABLE_W-1:0] mux_table_q  = '0;
  logic [ACC_W-1:0]       window_sum   = '0;
  logic [6:0]             window_fill  = '0;
  logic [SLOT_W-1:0]      scan_slot    = '0;
  logic [SAMPLE_W-1:0]    slot_avg [NCH] = '{default: '0};

  result_t owed_results [$];
  int      mismatches   = 0;
  int      results_seen = 0;
  int      cycle_count  = 0;
  int      quiet_in     = 0;
  int      quiet_out    = 0;

  adc_scan_averager u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Wait before the next beat: mostly random, with runs of back-to-back beats.
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // One beat through the scan: accumulate, close a window, or read an average.
  function automatic result_t averager_step(input item_t it);
    result_t r;
    int      span;
    int      next_slot;
    r    = '0;
    span = chan_count_q;
    if (span == 0) span = 1;
    if (span > NCH) span = NCH;
    if (it.kind == KIND_SAMPLE) begin
      if (window_fill < (1 << SHIFT)) begin
        window_fill = window_fill + 7'd1;
        window_sum  = window_sum + ACC_W'(it.sample);
      end else begin
        // The closing sample itself is dropped.
        if (scan_slot < NCH) slot_avg[scan_slot] = SAMPLE_W'(window_sum >> SHIFT);
        r.window_done   = 1'b1;
        r.finished_slot = scan_slot;
        next_slot = int'(scan_slot) + 1;
        if (next_slot >= span) next_slot = 0;
        scan_slot   = SLOT_W'(next_slot);
        window_sum  = '0;
        window_fill = '0;
      end
    end else begin
      if (it.read_channel < NCH) r.read_value = slot_avg[it.read_channel];
      r.start_conversion = ~it.conv_busy;
    end
    r.mux_code = mux_table_q[scan_slot*MUX_W +: MUX_W];
    return r;
  endfunction

  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] smp,
                           input logic [SLOT_W-1:0] rch, input logic busy);
    item_t it;
    int    w;
    logic  took;
    it.kind         = kind;
    it.sample       = smp;
    it.read_channel = rch;
    it.conv_busy    = busy;
    w = draw_wait(quiet_in);
    if (w > 0) begin
      s_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {2'b00, busy, rch, smp};
    do begin
      @(negedge clk);
      took = s_ready;
      @(posedge clk);
    end while (!took);
    owed_results.push_back(averager_step(it));
  endtask

  // Drop valid, let every owed result arrive, then a few cycles of slack.
  task automatic settle();
    s_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    if (idx == REG_CHANNEL_COUNT) chan_count_q = val[COUNT_W-1:0];
    else if (idx == REG_MUX_TABLE) mux_table_q = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stalls, one beat taken per handshake.
  initial begin : result_taker
    int   w;
    logic took;
    @(posedge clk);
    forever begin
      w = draw_wait(quiet_out);
      if (w > 0) begin
        m_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = m_valid && rst_n;
        @(posedge clk);
      end while (!took);
    end
  end

  // Signals are stable at the falling edge, so a handshake seen here is
  // the one that completes at the next rising edge.
  always @(negedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && m_valid && m_ready) begin
      got.mux_code         = m_data[3:0];
      got.read_value       = m_data[13:4];
      got.window_done      = m_data[14];
      got.finished_slot    = m_data[17:15];
      got.start_conversion = m_data[18];
      results_seen++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("result %0d arrived with nothing owed: tdata %h", results_seen, m_data);
      end else begin
        want = owed_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT) begin
            $write("result %0d: expected mux %h avg %0d done %b slot %0d start %b,",
                   results_seen, want.mux_code, want.read_value, want.window_done,
                   want.finished_slot, want.start_conversion);
            $display(" got mux %h avg %0d done %b slot %0d start %b",
                     got.mux_code, got.read_value, got.window_done, got.finished_slot,
                     got.start_conversion);
          end
        end
      end
    end
  end

  // Reads straight after reset see a zero store, with both busy values.
  task automatic test_reset_state();
    send_item(KIND_READ, '0, 3'd0, 1'b0);
    send_item(KIND_READ, '1, 3'd7, 1'b1);
    send_item(KIND_READ, '0, 3'd3, 1'b0);
  endtask

  // A full-scale window under the reset registers; the closing zero is dropped.
  task automatic test_full_scale_window();
    repeat (1 << SHIFT) send_item(KIND_SAMPLE, 10'd1023, 3'd5, 1'b1);
    send_item(KIND_SAMPLE, 10'd0, 3'd2, 1'b0);
    send_item(KIND_READ, 10'd0, 3'd0, 1'b0);
  endtask

  // An unknown index changes nothing; stray upper data bits are masked.
  task automatic test_register_writes();
    settle();
    write_reg(CFG_INDEX_W'(15), 32'h0000_0005);
    write_reg(REG_CHANNEL_COUNT, 32'hFFFF_FFF3);
    write_reg(REG_MUX_TABLE, 32'hFEDC_BA98);
    repeat (3 * ((1 << SHIFT) + 1)) send_item(KIND_SAMPLE, 10'($urandom_range(0, 1023)),
                                             3'($urandom_range(0, 7)), 1'($urandom));
    send_item(KIND_READ, '0, 3'd1, 1'b1);
  endtask

  // Phases of random traffic, each under its own slot count and mux table.
  // A count of zero, a count above CHANNELS, and a drop in count that leaves
  // the current slot past the list are all among the phases.
  task automatic test_random_scan();
    logic [COUNT_W-1:0] counts [8];
    int                 per_phase;
    int                 pick;
    logic [SAMPLE_W-1:0] smp;
    logic [MUX_TABLE_W-1:0] table_val;
    counts    = '{4'd8, 4'd2, 4'd15, 4'd0, 4'd5, 4'd1, 4'd7, 4'd3};
    per_phase = SCAN_ITEMS / 8;
    for (int p = 0; p < 8; p++) begin
      settle();
      if (p == 0) table_val = 32'hFFFF_FFFF;
      else if (p == 3) table_val = 32'h0000_0000;
      else table_val = $urandom;
      write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(counts[p]));
      write_reg(REG_MUX_TABLE, table_val);
      for (int i = 0; i < per_phase; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) smp = '0;
          else if (pick == 1) smp = '1;
          else smp = 10'($urandom_range(0, 1023));
          send_item(KIND_SAMPLE, smp, 3'($urandom_range(0, 7)), 1'($urandom));
        end else begin
          send_item(KIND_READ, 10'($urandom_range(0, 1023)), 3'($urandom_range(0, 7)),
                    1'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_full_scale_window();
    test_register_writes();
    test_random_scan();
    settle();
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
